// ===== hdl/fbtr_pkg.sv =====
// Shared constants, types and glyph ROM for the text and rectangle renderer.
package fbtr_pkg;

   localparam int PIXEL_W       = 16;
   localparam int COORD_W       = 12;
   localparam int GLYPH_COLUMNS = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int GLYPH_BITS    = 8 * GLYPH_COLUMNS;
   localparam int FIRST_CODE    = 32;
   localparam int LAST_CODE     = 126;
   localparam int GLYPH_COUNT   = LAST_CODE - FIRST_CODE + 1;

   localparam logic REG_ACTIVE_WIDTH  = 1'b0;
   localparam logic REG_ACTIVE_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      CMD_FILL = 2'd0,
      CMD_CHAR = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   // column 0 in the top byte, bit r of a column byte is glyph row r
   localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700,
      40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001C224100,
      40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10,
      40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E,
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
      40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h7F4030407F, 40'h6314081463,
      40'h0708700807, 40'h6151494543, 40'h00007F4100,
      40'h0204081020, 40'h00417F0000, 40'h0402010204,
      40'h4040404040, 40'h0001020400, 40'h2054545478,
      40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h081454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h007F102844, 40'h00417F4000, 40'h7C04180478,
      40'h7C08040478, 40'h3844444438, 40'h7C14141408,
      40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
      40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000,
      40'h0041360800, 40'h1008081008
   };

endpackage

// ===== hdl/framebuffer_text_rect_renderer.sv =====
// Top level: rectangle fill, 5x7 glyph drawing and pixel readback over a frame store.
//
//   channel   ports                        transfer
//   -------   --------------------------   ---------------------------------
//   request   start, busy, req_*           start high while busy low
//   response  rsp_strobe, rsp_pixel_value  rsp_strobe high, one cycle, no stall
//   config    csr_write_enable, csr_*      csr_write_enable high
//
// After reset the store is swept to zero, one pixel a cycle, with busy high. A
// command passes setup and a row-base multiply, then the pixel address unit writes
// one pixel per cycle: a fill over its clipped area, a character over all
// 35*scale*scale cells (off-screen cells included). An in-area read then issues
// a read and takes the data; any read answers in the same cycle busy drops.
// Rejected codes, scale zero, empty fills, unused commands, outside reads end at setup.
module framebuffer_text_rect_renderer #(
   parameter int MAX_WIDTH  = 240,
   parameter int MAX_HEIGHT = 320
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_command,
   input  logic signed [10:0]                 req_pos_x,
   input  logic signed [10:0]                 req_pos_y,
   input  logic [9:0]                         req_rect_width,
   input  logic [9:0]                         req_rect_height,
   input  logic [7:0]                         req_char_code,
   input  logic [fbtr_pkg::PIXEL_W-1:0]       req_fg_color,
   input  logic [fbtr_pkg::PIXEL_W-1:0]       req_bg_color,
   input  logic [3:0]                         req_scale,
   output logic                               rsp_strobe,
   output logic [fbtr_pkg::PIXEL_W-1:0]       rsp_pixel_value,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [8:0]                         csr_write_data
);
   import fbtr_pkg::*;

   localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int RB_W     = COORD_W + 9;
   localparam int AW_RESET = (MAX_WIDTH < 240) ? MAX_WIDTH : 240;
   localparam int AH_RESET = (MAX_HEIGHT < 320) ? MAX_HEIGHT : 320;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SETUP,
      ST_MUL,
      ST_SCAN,
      ST_RD_ISSUE,
      ST_RD_DATA
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]                active_width_ff, active_width_in;
   logic [8:0]                active_height_ff, active_height_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [PIXEL_W-1:0]        rsp_pixel_ff, rsp_pixel_in;
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;

   logic [1:0]                cmd_ff, cmd_in;
   logic signed [COORD_W-1:0] x_ff, x_in;
   logic signed [COORD_W-1:0] y_ff, y_in;
   logic [9:0]                w_ff, w_in;
   logic [9:0]                h_ff, h_in;
   logic [7:0]                code_ff, code_in;
   logic [PIXEL_W-1:0]        fg_ff, fg_in;
   logic [PIXEL_W-1:0]        bg_ff, bg_in;
   logic [3:0]                scale_ff, scale_in;

   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic signed [COORD_W-1:0] x_start_ff, x_start_in;
   logic signed [COORD_W-1:0] x_end_ff, x_end_in;
   logic signed [COORD_W-1:0] y_end_ff, y_end_in;
   logic signed [RB_W-1:0]    row_base_ff, row_base_in;
   logic [GLYPH_BITS-1:0]     glyph_ff, glyph_in;
   logic [3:0]                sx_ff, sx_in;
   logic [3:0]                sy_ff, sy_in;
   logic [2:0]                col_ff, col_in;
   logic [2:0]                grow_ff, grow_in;

   logic signed [COORD_W-1:0] aw_s, ah_s;
   logic signed [COORD_W-1:0] x_sum, y_sum;
   logic signed [COORD_W-1:0] fx0, fx1, fy0, fy1;
   logic signed [COORD_W-1:0] cx_next, cy_next;
   logic signed [RB_W-1:0]    pix_sum;
   logic [ADDR_W-1:0]         pix_addr;
   logic [7:0]                glyph_off;
   logic [6:0]                glyph_idx;
   logic [7:0]                col_byte;
   logic                      lit;
   logic                      in_area;
   logic                      row_end, last_row;
   logic                      code_ok;

   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [PIXEL_W-1:0]        mem_wdata;
   logic                      mem_re;
   logic [PIXEL_W-1:0]        mem_rdata;

   fbtr_frame_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (pix_addr),
      .rd_data (mem_rdata)
   );

   assign aw_s      = $signed(COORD_W'(active_width_ff));
   assign ah_s      = $signed(COORD_W'(active_height_ff));
   assign x_sum     = x_ff + $signed(COORD_W'(w_ff));
   assign y_sum     = y_ff + $signed(COORD_W'(h_ff));
   assign fx0       = x_ff[COORD_W-1] ? '0 : x_ff;
   assign fy0       = y_ff[COORD_W-1] ? '0 : y_ff;
   assign fx1       = (x_sum < aw_s) ? x_sum : aw_s;
   assign fy1       = (y_sum < ah_s) ? y_sum : ah_s;
   assign cx_next   = cx_ff + COORD_W'(1);
   assign cy_next   = cy_ff + COORD_W'(1);
   assign pix_sum   = row_base_ff + RB_W'(cx_ff);
   assign pix_addr  = pix_sum[ADDR_W-1:0];
   assign glyph_off = code_ff - 8'(FIRST_CODE);
   assign glyph_idx = glyph_off[6:0];
   assign col_byte  = glyph_ff[{3'(GLYPH_COLUMNS - 1) - col_ff, 3'b000} +: 8];
   assign lit       = col_byte[grow_ff];
   assign code_ok   = (code_ff >= 8'(FIRST_CODE)) && (code_ff <= 8'(LAST_CODE))
                      && (scale_ff != 4'd0);
   assign in_area   = !cx_ff[COORD_W-1] && (cx_ff < aw_s)
                      && !cy_ff[COORD_W-1] && (cy_ff < ah_s);
   assign row_end   = (cmd_ff == CMD_FILL) ? (cx_next == x_end_ff)
                      : ((sx_ff == scale_ff - 4'd1) && (col_ff == 3'(GLYPH_COLUMNS - 1)));
   assign last_row  = (cmd_ff == CMD_FILL) ? (cy_next == y_end_ff)
                      : ((sy_ff == scale_ff - 4'd1) && (grow_ff == 3'(GLYPH_ROWS - 1)));

   always_comb begin
      state_in         = state_ff;
      active_width_in  = active_width_ff;
      active_height_in = active_height_ff;
      rsp_strobe_in    = 1'b0;
      rsp_pixel_in     = rsp_pixel_ff;
      clr_addr_in      = clr_addr_ff;
      cmd_in           = cmd_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      w_in             = w_ff;
      h_in             = h_ff;
      code_in          = code_ff;
      fg_in            = fg_ff;
      bg_in            = bg_ff;
      scale_in         = scale_ff;
      cx_in            = cx_ff;
      cy_in            = cy_ff;
      x_start_in       = x_start_ff;
      x_end_in         = x_end_ff;
      y_end_in         = y_end_ff;
      row_base_in      = row_base_ff;
      glyph_in         = glyph_ff;
      sx_in            = sx_ff;
      sy_in            = sy_ff;
      col_in           = col_ff;
      grow_in          = grow_ff;
      mem_we           = 1'b0;
      mem_waddr        = pix_addr;
      mem_wdata        = fg_ff;
      mem_re           = 1'b0;

      if (csr_write_enable) begin
         if (csr_index == REG_ACTIVE_WIDTH) begin
            active_width_in = ({3'b000, csr_write_data[7:0]} > 11'(MAX_WIDTH))
                              ? 8'(MAX_WIDTH) : csr_write_data[7:0];
         end else begin
            active_height_in = ({2'b00, csr_write_data} > 11'(MAX_HEIGHT))
                               ? 9'(MAX_HEIGHT) : csr_write_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               x_in     = COORD_W'(req_pos_x);
               y_in     = COORD_W'(req_pos_y);
               w_in     = req_rect_width;
               h_in     = req_rect_height;
               code_in  = req_char_code;
               fg_in    = req_fg_color;
               bg_in    = req_bg_color;
               scale_in = req_scale;
               state_in = ST_SETUP;
            end
         end
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            sx_in   = '0;
            sy_in   = '0;
            col_in  = '0;
            grow_in = '0;
            case (cmd_ff)
               CMD_FILL: begin
                  cx_in      = fx0;
                  cy_in      = fy0;
                  x_start_in = fx0;
                  x_end_in   = fx1;
                  y_end_in   = fy1;
                  state_in   = ((fx0 >= fx1) || (fy0 >= fy1)) ? ST_IDLE : ST_MUL;
               end
               CMD_CHAR: begin
                  cx_in      = x_ff;
                  cy_in      = y_ff;
                  x_start_in = x_ff;
                  glyph_in   = GLYPH_ROM[glyph_idx];
                  state_in   = code_ok ? ST_MUL : ST_IDLE;
               end
               CMD_READ: begin
                  cx_in = x_ff;
                  cy_in = y_ff;
                  if (!x_ff[COORD_W-1] && (x_ff < aw_s) && !y_ff[COORD_W-1] && (y_ff < ah_s)) begin
                     state_in = ST_MUL;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_pixel_in  = '0;
                     state_in      = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MUL: begin
            row_base_in = RB_W'(cy_ff) * RB_W'($signed({1'b0, active_width_ff}));
            state_in    = (cmd_ff == CMD_READ) ? ST_RD_ISSUE : ST_SCAN;
         end
         ST_SCAN: begin
            mem_we    = in_area;
            mem_wdata = ((cmd_ff == CMD_FILL) || lit) ? fg_ff : bg_ff;
            if (sx_ff == scale_ff - 4'd1) begin
               sx_in  = '0;
               col_in = (col_ff == 3'(GLYPH_COLUMNS - 1)) ? 3'd0 : col_ff + 3'd1;
            end else begin
               sx_in = sx_ff + 4'd1;
            end
            if (row_end) begin
               cx_in       = x_start_ff;
               cy_in       = cy_next;
               row_base_in = row_base_ff + RB_W'($signed({1'b0, active_width_ff}));
               if (sy_ff == scale_ff - 4'd1) begin
                  sy_in   = '0;
                  grow_in = grow_ff + 3'd1;
               end else begin
                  sy_in = sy_ff + 4'd1;
               end
               if (last_row) begin
                  state_in = ST_IDLE;
               end
            end else begin
               cx_in = cx_next;
            end
         end
         ST_RD_ISSUE: begin
            mem_re   = 1'b1;
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            rsp_strobe_in = 1'b1;
            rsp_pixel_in  = mem_rdata;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_addr_ff      <= '0;
         active_width_ff  <= 8'(AW_RESET);
         active_height_ff <= 9'(AH_RESET);
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_addr_ff      <= clr_addr_in;
         active_width_ff  <= active_width_in;
         active_height_ff <= active_height_in;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      code_ff      <= code_in;
      fg_ff        <= fg_in;
      bg_ff        <= bg_in;
      scale_ff     <= scale_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      x_start_ff   <= x_start_in;
      x_end_ff     <= x_end_in;
      y_end_ff     <= y_end_in;
      row_base_ff  <= row_base_in;
      glyph_ff     <= glyph_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      col_ff       <= col_in;
      grow_ff      <= grow_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

endmodule

// ===== hdl/fbtr_frame_store.sv =====
// Single-port-write, single-port-read pixel memory with registered read data.
module fbtr_frame_store #(
   parameter int DEPTH  = 76800,
   parameter int ADDR_W = 17
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [fbtr_pkg::PIXEL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [fbtr_pkg::PIXEL_W-1:0] rd_data
);
   import fbtr_pkg::*;

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
